// ----- rtl/utf8_to_utf16_converter_macros.svh -----
// Assertion macros for the UTF-8 to UTF-16 converter
`ifndef UTF8_TO_UTF16_CONVERTER_MACROS_SVH
`define UTF8_TO_UTF16_CONVERTER_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define U2U_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the following cycle
`define U2U_ASSERT_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) else $error(msg);

`endif

// ----- rtl/u8u16_pkg.sv -----
// Types and constants shared by the UTF-8 to UTF-16 converter
package u8u16_pkg;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 88;

	// lead and follow byte class boundaries
	localparam logic [7:0] BYTE_ASCII_END = 8'h80;
	localparam logic [7:0] BYTE_LEAD2     = 8'hc0;
	localparam logic [7:0] BYTE_LEAD3     = 8'he0;
	localparam logic [7:0] BYTE_LEAD4     = 8'hf0;
	localparam logic [7:0] BYTE_BAD_LEAD  = 8'hf8;

	// code point limits
	localparam logic [20:0] CP_MIN2      = 21'h000080;
	localparam logic [20:0] CP_MIN3      = 21'h000800;
	localparam logic [20:0] CP_SURR_LO   = 21'h00d800;
	localparam logic [20:0] CP_SURR_END  = 21'h00e000;
	localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
	localparam logic [20:0] CP_MAX       = 21'h10ffff;

	localparam logic [15:0] HIGH_SURR = 16'hd800;
	localparam logic [15:0] LOW_SURR  = 16'hdc00;
	localparam logic [9:0]  SURR_MASK = 10'h3ff;

	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	localparam logic REP_UNIT  = 1'b0;
	localparam logic REP_COUNT = 1'b1;

	// all results caused by one input byte
	typedef struct packed {
		logic [1:0]  n_units;
		logic        rep;
		logic [15:0] u0;
		logic [15:0] u1;
		logic [31:0] bytes;
		logic [31:0] units;
		logic        stop;
	} bundle_t;

endpackage

// ----- rtl/utf8_to_utf16_converter.sv -----
// UTF-8 to UTF-16 converter: byte decoder, counters and result queue
//
// Takes one UTF-8 byte per transaction and accepts a byte in every cycle while
// its two-entry result queue has room. Each byte is decoded in the cycle it is
// accepted and its results (up to two code units and, on the buffer's last byte,
// a count report) are written as one queue entry. Results leave at one per
// cycle while m_tready is high, so a byte that gives a surrogate pair or closes
// the buffer with a code unit sends its results in turn; with m_tready high, the
// sustained input rate is one byte per cycle while each byte yields at most one result.
// The counters are COUNT_WIDTH bits wide and report their low 32 bits.
`include "utf8_to_utf16_converter_macros.svh"

module utf8_to_utf16_converter #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] data_byte
	input  logic [u8u16_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] code_unit, [47:16] bytes_translated, [79:48] units_written,
	// [80] stopped_early, [87:81] zero
	output logic [u8u16_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] report_kind
	output logic [0:0]                        m_tuser,
	output logic                              m_tlast
);

	logic [20:0]            cp_q;
	logic [1:0]             follow_q;
	logic [2:0]             seqlen_q;
	logic                   halted_q;
	logic [COUNT_WIDTH-1:0] byte_cnt_q;
	logic [COUNT_WIDTH-1:0] unit_cnt_q;

	logic [20:0]            cp_n;
	logic [1:0]             follow_n;
	logic [2:0]             seqlen_n;
	logic                   halt_n;
	logic [COUNT_WIDTH-1:0] bc_n;
	logic [COUNT_WIDTH-1:0] uc_n;
	logic [20:0]            cp_ext;
	logic [20:0]            cp_off;
	logic                   seq_ok;
	logic [7:0]             b;
	u8u16_pkg::bundle_t     bnd;

	u8u16_pkg::bundle_t     bq_q [2];
	logic                   head_q;
	logic                   tail_q;
	logic [1:0]             bq_count_q;
	logic [1:0]             idx_q;

	u8u16_pkg::bundle_t     hd;
	logic [1:0]             hd_total;
	logic                   out_last;
	logic                   acc;
	logic                   push;
	logic                   pop;
	logic [15:0]            out_unit;

	assign b      = s_tdata;
	assign acc    = s_tvalid && s_tready;
	assign cp_ext = {cp_q[14:0], b[5:0]};
	assign cp_off = cp_ext - u8u16_pkg::CP_SUPP_BASE;

	always_comb begin
		cp_n       = cp_q;
		follow_n   = follow_q;
		seqlen_n   = seqlen_q;
		halt_n     = halted_q;
		bc_n       = byte_cnt_q;
		seq_ok     = 1'b0;
		bnd        = '0;
		if (!halted_q) begin
			if (follow_q == 2'd0) begin
				if (b < u8u16_pkg::BYTE_ASCII_END) begin
					bnd.n_units = 2'd1;
					bnd.u0      = {8'h00, b};
					bc_n        = byte_cnt_q + COUNT_WIDTH'(1);
				end else if (b >= u8u16_pkg::BYTE_LEAD2 && b < u8u16_pkg::BYTE_LEAD3) begin
					cp_n     = {16'h0000, b[4:0]};
					seqlen_n = u8u16_pkg::SEQ_LEN2;
					follow_n = 2'd1;
				end else if (b >= u8u16_pkg::BYTE_LEAD3 && b < u8u16_pkg::BYTE_LEAD4) begin
					cp_n     = {17'h00000, b[3:0]};
					seqlen_n = u8u16_pkg::SEQ_LEN3;
					follow_n = 2'd2;
				end else if (b >= u8u16_pkg::BYTE_LEAD4 && b < u8u16_pkg::BYTE_BAD_LEAD) begin
					cp_n     = {18'h00000, b[2:0]};
					seqlen_n = u8u16_pkg::SEQ_LEN4;
					follow_n = 2'd3;
				end else begin
					halt_n = 1'b1;
				end
			end else if (b < u8u16_pkg::BYTE_ASCII_END || b >= u8u16_pkg::BYTE_LEAD2) begin
				halt_n = 1'b1;
			end else begin
				cp_n     = cp_ext;
				follow_n = follow_q - 2'd1;
				if (follow_q == 2'd1) begin
					if (seqlen_q == u8u16_pkg::SEQ_LEN2)
						seq_ok = cp_ext >= u8u16_pkg::CP_MIN2;
					else if (seqlen_q == u8u16_pkg::SEQ_LEN3)
						seq_ok = cp_ext >= u8u16_pkg::CP_MIN3 &&
							!(cp_ext >= u8u16_pkg::CP_SURR_LO &&
							  cp_ext < u8u16_pkg::CP_SURR_END);
					else
						seq_ok = cp_ext >= u8u16_pkg::CP_SUPP_BASE &&
							cp_ext <= u8u16_pkg::CP_MAX;
					if (!seq_ok) begin
						halt_n = 1'b1;
					end else if (seqlen_q == u8u16_pkg::SEQ_LEN4) begin
						bnd.n_units = 2'd2;
						bnd.u0      = u8u16_pkg::HIGH_SURR | {6'd0, cp_off[19:10]};
						bnd.u1      = u8u16_pkg::LOW_SURR |
							{6'd0, cp_off[9:0] & u8u16_pkg::SURR_MASK};
					end else begin
						bnd.n_units = 2'd1;
						bnd.u0      = cp_ext[15:0];
					end
					if (seq_ok)
						bc_n = byte_cnt_q + COUNT_WIDTH'(seqlen_q);
				end
			end
		end
		uc_n      = unit_cnt_q + COUNT_WIDTH'(bnd.n_units);
		bnd.rep   = s_tlast;
		bnd.bytes = s_tlast ? 32'(bc_n) : 32'd0;
		bnd.units = s_tlast ? 32'(uc_n) : 32'd0;
		bnd.stop  = s_tlast && (halt_n || follow_n != 2'd0);
		if (s_tlast) begin
			cp_n     = '0;
			follow_n = '0;
			seqlen_n = '0;
			halt_n   = 1'b0;
			bc_n     = '0;
			uc_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q       <= '0;
			follow_q   <= '0;
			seqlen_q   <= '0;
			halted_q   <= 1'b0;
			byte_cnt_q <= '0;
			unit_cnt_q <= '0;
		end else if (acc) begin
			cp_q       <= cp_n;
			follow_q   <= follow_n;
			seqlen_q   <= seqlen_n;
			halted_q   <= halt_n;
			byte_cnt_q <= bc_n;
			unit_cnt_q <= uc_n;
		end
	end

	// result queue: one entry per byte that yields anything
	assign hd       = bq_q[head_q];
	assign hd_total = hd.n_units + {1'b0, hd.rep};
	assign out_last = idx_q == (hd_total - 2'd1);
	assign m_tvalid = bq_count_q != 2'd0;
	assign s_tready = bq_count_q != 2'd2;
	assign push     = acc && (bnd.n_units != 2'd0 || s_tlast);
	assign pop      = m_tvalid && m_tready && out_last;

	always_ff @(posedge clk) begin
		if (push)
			bq_q[tail_q] <= bnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= 1'b0;
			tail_q     <= 1'b0;
			bq_count_q <= '0;
			idx_q      <= '0;
		end else begin
			if (push)
				tail_q <= !tail_q;
			if (pop)
				head_q <= !head_q;
			bq_count_q <= bq_count_q + {1'b0, push} - {1'b0, pop};
			if (pop)
				idx_q <= '0;
			else if (m_tvalid && m_tready)
				idx_q <= idx_q + 2'd1;
		end
	end

	always_comb begin
		out_unit = 16'h0000;
		m_tuser  = u8u16_pkg::REP_COUNT;
		if (idx_q < hd.n_units) begin
			m_tuser  = u8u16_pkg::REP_UNIT;
			out_unit = idx_q[0] ? hd.u1 : hd.u0;
		end
	end

	assign m_tdata = (m_tuser[0] == u8u16_pkg::REP_COUNT) ?
		{7'd0, hd.stop, hd.units, hd.bytes, 16'h0000} :
		{7'd0, 1'b0, 32'd0, 32'd0, out_unit};
	assign m_tlast = out_last;

	`U2U_ASSERT(a_queue_bound, bq_count_q != 2'd3, "result queue count out of range")
	`U2U_ASSERT(a_report_last, !(m_tvalid && m_tuser[0]) || m_tlast,
		"count report is not the final result of its byte")
	`U2U_ASSERT(a_high_surr_pair,
		!(m_tvalid && !m_tuser[0] && m_tdata[15:10] == 6'b110110) || !m_tlast,
		"high surrogate without following low surrogate")
	`U2U_ASSERT_NEXT(a_clear_after_end, s_tvalid && s_tready && s_tlast,
		!halted_q && follow_q == 2'd0 && byte_cnt_q == '0 && unit_cnt_q == '0,
		"state not cleared after buffer end")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the UTF-8 to UTF-16 converter: stimulus, decoder model, checker
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_BYTES = 260;
	localparam int HOLD_CYCLES  = 80;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} in_byte_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        kind;
		logic [31:0] nbytes;
		logic [31:0] nunits;
		logic        stop;
		logic        last;
	} utf16_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [u8u16_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                             s_tlast = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [u8u16_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [0:0]                       m_tuser;
	logic                             m_tlast;

	in_byte_t      byte_queue[$];
	logic [7:0]    buf_bytes[$];
	utf16_result_t expected_results[$];

	// decoder model state
	logic [20:0] acc_cp = '0;
	logic [1:0]  need_follow = '0;
	logic [2:0]  seq_bytes = '0;
	logic        stuck = 1'b0;
	logic [31:0] cnt_bytes = '0;
	logic [31:0] cnt_units = '0;

	int mismatch_count = 0;
	int cycle_count = 0;
	int bytes_in = 0;
	int buffers_built = 0;
	int units_seen = 0;
	int reports_seen = 0;
	int stops_seen = 0;

	logic calm = 1'b0;
	logic src_bursty = 1'b1;
	logic sink_bursty = 1'b1;
	int   src_gap = 0;
	int   sink_gap = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	utf8_to_utf16_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic utf16_result_t make_result(input logic [15:0] unit, input logic kind,
			input logic [31:0] nb, input logic [31:0] nu, input logic stop);
		utf16_result_t r;
		r.code_unit = unit;
		r.kind      = kind;
		r.nbytes    = nb;
		r.nunits    = nu;
		r.stop      = stop;
		r.last      = 1'b0;
		return r;
	endfunction

	// Model of one accepted byte: queues the code units and report it causes
	task automatic decode_utf8_byte(input logic [7:0] b, input logic eob);
		utf16_result_t res [3];
		int            n;
		int            i;
		logic [20:0]   c;
		logic [19:0]   v;
		logic          ok;
		n = 0;
		if (!stuck) begin
			if (need_follow == 2'd0) begin
				if (b < u8u16_pkg::BYTE_ASCII_END) begin
					res[n] = make_result({8'h00, b}, u8u16_pkg::REP_UNIT, '0, '0, 1'b0);
					n++;
					cnt_units++;
					cnt_bytes++;
				end else if (b >= u8u16_pkg::BYTE_LEAD2 && b < u8u16_pkg::BYTE_LEAD3) begin
					acc_cp = {16'd0, b[4:0]};
					seq_bytes = u8u16_pkg::SEQ_LEN2;
					need_follow = 2'd1;
				end else if (b >= u8u16_pkg::BYTE_LEAD3 && b < u8u16_pkg::BYTE_LEAD4) begin
					acc_cp = {17'd0, b[3:0]};
					seq_bytes = u8u16_pkg::SEQ_LEN3;
					need_follow = 2'd2;
				end else if (b >= u8u16_pkg::BYTE_LEAD4 && b < u8u16_pkg::BYTE_BAD_LEAD) begin
					acc_cp = {18'd0, b[2:0]};
					seq_bytes = u8u16_pkg::SEQ_LEN4;
					need_follow = 2'd3;
				end else begin
					stuck = 1'b1;
				end
			end else if (b < u8u16_pkg::BYTE_ASCII_END || b >= u8u16_pkg::BYTE_LEAD2) begin
				stuck = 1'b1;
			end else begin
				c = {acc_cp[14:0], b[5:0]};
				acc_cp = c;
				need_follow--;
				if (need_follow == 2'd0) begin
					case (seq_bytes)
						u8u16_pkg::SEQ_LEN2: ok = c >= u8u16_pkg::CP_MIN2;
						u8u16_pkg::SEQ_LEN3: ok = c >= u8u16_pkg::CP_MIN3 &&
							!(c >= u8u16_pkg::CP_SURR_LO && c < u8u16_pkg::CP_SURR_END);
						default: ok = c >= u8u16_pkg::CP_SUPP_BASE && c <= u8u16_pkg::CP_MAX;
					endcase
					if (!ok) begin
						stuck = 1'b1;
					end else begin
						if (seq_bytes == u8u16_pkg::SEQ_LEN4) begin
							v = 20'(c - u8u16_pkg::CP_SUPP_BASE);
							res[n] = make_result(u8u16_pkg::HIGH_SURR | {6'd0, v[19:10]},
								u8u16_pkg::REP_UNIT, '0, '0, 1'b0);
							n++;
							res[n] = make_result(u8u16_pkg::LOW_SURR |
								{6'd0, v[9:0] & u8u16_pkg::SURR_MASK},
								u8u16_pkg::REP_UNIT, '0, '0, 1'b0);
							n++;
							cnt_units += 2;
						end else begin
							res[n] = make_result(c[15:0], u8u16_pkg::REP_UNIT, '0, '0, 1'b0);
							n++;
							cnt_units++;
						end
						cnt_bytes += 32'(seq_bytes);
					end
				end
			end
		end
		if (eob) begin
			// a truncated tail counts as stopped just like an error
			res[n] = make_result('0, u8u16_pkg::REP_COUNT, cnt_bytes, cnt_units,
				stuck || need_follow != 2'd0);
			n++;
			acc_cp = '0;
			need_follow = '0;
			seq_bytes = '0;
			stuck = 1'b0;
			cnt_bytes = '0;
			cnt_units = '0;
		end
		for (i = 0; i < n; i++) begin
			res[i].last = (i == n - 1);
			expected_results.push_back(res[i]);
		end
	endtask

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// encode a code point in len bytes, overlong and out-of-range forms included
	task automatic put_cp(input logic [20:0] cp, input int len);
		case (len)
			1: buf_bytes.push_back(cp[7:0]);
			2: begin
				buf_bytes.push_back({3'b110, cp[10:6]});
				buf_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				buf_bytes.push_back({4'b1110, cp[15:12]});
				buf_bytes.push_back({2'b10, cp[11:6]});
				buf_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				buf_bytes.push_back({5'b11110, cp[20:18]});
				buf_bytes.push_back({2'b10, cp[17:12]});
				buf_bytes.push_back({2'b10, cp[11:6]});
				buf_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic close_buffer();
		in_byte_t it;
		int       i;
		for (i = 0; i < buf_bytes.size(); i++) begin
			it.data = buf_bytes[i];
			it.last = (i == buf_bytes.size() - 1);
			byte_queue.push_back(it);
		end
		buf_bytes.delete();
		buffers_built++;
	endtask

	task automatic put_lead(input int len);
		case (len)
			2:       buf_bytes.push_back(8'($urandom_range(8'hc2, 8'hdf)));
			3:       buf_bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
			default: buf_bytes.push_back(8'($urandom_range(8'hf0, 8'hf4)));
		endcase
	endtask

	task automatic put_random_char(input int kind);
		int len;
		int i;
		case (kind)
			0, 1, 2, 3, 4: put_cp(21'($urandom_range(0, 8'h7f)), 1);
			5, 6, 7, 8:    put_cp(21'($urandom_range(12'h080, 12'h7ff)), 2);
			9, 10, 11: begin
				if ($urandom_range(0, 1) == 0)
					put_cp(21'($urandom_range(16'h0800, 16'hd7ff)), 3);
				else
					put_cp(21'($urandom_range(16'he000, 16'hffff)), 3);
			end
			12, 13, 14:    put_cp(21'($urandom_range(21'h010000, 21'h10ffff)), 4);
			15: begin
				// overlong form
				len = $urandom_range(2, 4);
				if (len == 2)
					put_cp(21'($urandom_range(0, 8'h7f)), 2);
				else if (len == 3)
					put_cp(21'($urandom_range(0, 12'h7ff)), 3);
				else
					put_cp(21'($urandom_range(0, 16'hffff)), 4);
			end
			16: begin
				if ($urandom_range(0, 1) == 0)
					put_cp(21'($urandom_range(16'hd800, 16'hdfff)), 3);
				else
					put_cp(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
			end
			17: buf_bytes.push_back(8'($urandom_range(0, 255)));
			18: begin
				// lead followed by something that is not a follow byte
				len = $urandom_range(2, 4);
				put_lead(len);
				for (i = 0; i < $urandom_range(0, len - 2); i++)
					buf_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
				if ($urandom_range(0, 1) == 0)
					buf_bytes.push_back(8'($urandom_range(0, 8'h7f)));
				else
					buf_bytes.push_back(8'($urandom_range(8'hc0, 8'hff)));
			end
			default: begin
				// sequence cut short
				len = $urandom_range(2, 4);
				put_lead(len);
				for (i = 0; i < $urandom_range(0, len - 2); i++)
					buf_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
			end
		endcase
	endtask

	// source side
	always @(posedge clk) begin
		in_byte_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap  <= 0;
		end else begin
			calm <= byte_queue.size() < 40;
			if ($urandom_range(0, 49) == 0)
				src_bursty <= ~src_bursty;
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap  <= src_gap - 1;
				end else if (byte_queue.size() != 0 && src_bursty && !calm &&
						$urandom_range(0, 5) == 0) begin
					s_tvalid <= 1'b0;
					src_gap  <= $urandom_range(0, 4);
				end else if (byte_queue.size() != 0) begin
					it = byte_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= it.data;
					s_tlast  <= it.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off once the stream is under way
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && bytes_in >= 60) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// sink side
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if ($urandom_range(0, 49) == 0)
				sink_bursty <= ~sink_bursty;
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (sink_gap != 0) begin
				m_tready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else if (sink_bursty && !calm && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				sink_gap <= $urandom_range(0, 4);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		utf16_result_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_utf8_byte(s_tdata, s_tlast);
				bytes_in <= bytes_in + 1;
			end
			if (m_tvalid && m_tready) begin
				if (m_tuser[0] == u8u16_pkg::REP_COUNT) begin
					reports_seen++;
					if (m_tdata[80])
						stops_seen++;
				end else begin
					units_seen++;
				end
				if (expected_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected transaction tdata=%h tuser=%b",
						m_tdata, m_tuser));
				end else begin
					w = expected_results.pop_front();
					if (m_tdata[15:0] !== w.code_unit)
						flag_mismatch($sformatf("code_unit %h, want %h", m_tdata[15:0],
							w.code_unit));
					if (m_tuser[0] !== w.kind)
						flag_mismatch($sformatf("report_kind %b, want %b", m_tuser[0], w.kind));
					if (m_tdata[47:16] !== w.nbytes)
						flag_mismatch($sformatf("bytes_translated %0d, want %0d",
							m_tdata[47:16], w.nbytes));
					if (m_tdata[79:48] !== w.nunits)
						flag_mismatch($sformatf("units_written %0d, want %0d",
							m_tdata[79:48], w.nunits));
					if (m_tdata[80] !== w.stop)
						flag_mismatch($sformatf("stopped_early %b, want %b", m_tdata[80], w.stop));
					if (m_tlast !== w.last)
						flag_mismatch($sformatf("last_in_run %b, want %b", m_tlast, w.last));
					if (m_tdata[87:81] !== 7'd0)
						flag_mismatch($sformatf("tdata padding %b not zero", m_tdata[87:81]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("utf8_to_utf16_converter regression: fail");
			$finish;
		end
	end

	initial begin
		int chars;
		int spoil_at;
		int i;
		// boundaries of every sequence length, surrogate pair closing the buffer
		put_cp(21'h000000, 1);
		put_cp(21'h000080, 2);
		put_cp(21'h000800, 3);
		put_cp(21'h00ffff, 3);
		put_cp(21'h010000, 4);
		put_cp(21'h10ffff, 4);
		close_buffer();
		// encoded surrogate halts, trailing ASCII is ignored
		put_cp(21'h00d800, 3);
		buf_bytes.push_back(8'h41);
		close_buffer();
		// truncated tail
		buf_bytes.push_back(8'he2);
		buf_bytes.push_back(8'h82);
		close_buffer();
		// bad lead as the only byte
		buf_bytes.push_back(8'hff);
		close_buffer();
		put_cp(21'h00007f, 1);
		close_buffer();

		// random buffers: mostly clean text, one in three spoilt somewhere
		while (byte_queue.size() < RANDOM_BYTES - 15) begin
			chars = $urandom_range(1, 10);
			spoil_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, chars - 1) : -1;
			for (i = 0; i < chars; i++)
				put_random_char((i == spoil_at) ? $urandom_range(15, 19) : $urandom_range(0, 14));
			close_buffer();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (byte_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (expected_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("covered %0d bytes in %0d buffers: %0d code units, %0d count reports",
			bytes_in, buffers_built, units_seen, reports_seen);
		$display("%0d buffers stopped early, %0d mismatches", stops_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("utf8_to_utf16_converter regression: pass");
		else
			$display("utf8_to_utf16_converter regression: fail");
		$finish;
	end

endmodule
